@@ rtl/eprc_pkg.sv @@
// Shared types, constants and speed tables for the encoder position ramp controller.
`timescale 1ns / 1ps

package eprc_pkg;

  localparam int POS_W       = 24;
  localparam int SPEED_W     = 14;
  localparam int TICK_W      = 16;
  localparam int STEP_W      = 6;
  localparam int PHASE_W     = 3;
  localparam int STEP_LEVELS = 32;
  localparam int TABLE_LEN   = 32;
  localparam int TABLE_IDX_W = 5;

  // Divide by constant through multiply by reciprocal: floor(x * RECIP / 2^RECIP_SHIFT).
  // Exact for x < 2^24, because RECIP * D - 2^RECIP_SHIFT = 52 and 52 * 2^24 < 2^31.
  localparam int RECIP_W     = 25;
  localparam int RECIP_SHIFT = 31;
  localparam int PROD_W      = POS_W + RECIP_W;
  localparam int QUOT_W      = PROD_W - RECIP_SHIFT;
  localparam logic [RECIP_W-1:0] RECIP_TRAVEL = 25'd21474837; // 1/100
  localparam logic [RECIP_W-1:0] RECIP_ERR    = 25'd28633116; // 1/75

  // Phase codes of the tick sequence.
  localparam logic [PHASE_W-1:0] PH_IDLE  = 3'd0;
  localparam logic [PHASE_W-1:0] PH_STEP  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_SPEED = 3'd2;
  localparam logic [PHASE_W-1:0] PH_WAIT  = 3'd3;
  localparam logic [PHASE_W-1:0] PH_STOP  = 3'd4;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_TRAVEL    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_MODE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_INTERVAL = 2'd2;

  localparam logic [POS_W-1:0]  RST_FULL_TRAVEL    = 24'd100000;
  localparam logic [TICK_W-1:0] RST_ACCEL_INTERVAL = 16'd150;
  localparam logic [SPEED_W-1:0] MAX_PERIOD        = 14'd14336;

  localparam logic [SPEED_W-1:0] LIN_PERIOD [TABLE_LEN] = '{
    14'd448, 14'd224, 14'd149, 14'd112, 14'd89, 14'd74, 14'd64, 14'd56,
    14'd49,  14'd44,  14'd40,  14'd37,  14'd34, 14'd32, 14'd29, 14'd28,
    14'd26,  14'd24,  14'd23,  14'd22,  14'd21, 14'd20, 14'd19, 14'd18,
    14'd17,  14'd17,  14'd16,  14'd16,  14'd15, 14'd14, 14'd14, 14'd14
  };

  localparam logic [SPEED_W-1:0] EXP_PERIOD [TABLE_LEN] = '{
    14'd14336, 14'd3584, 14'd1593, 14'd896, 14'd573, 14'd398, 14'd293, 14'd224,
    14'd177,   14'd143,  14'd118,  14'd100, 14'd85,  14'd73,  14'd64,  14'd56,
    14'd50,    14'd44,   14'd40,   14'd36,  14'd33,  14'd30,  14'd27,  14'd25,
    14'd23,    14'd21,   14'd20,   14'd18,  14'd17,  14'd16,  14'd15,  14'd14
  };

  typedef struct packed {
    logic [POS_W-1:0]  full_travel;
    logic              speed_mode;
    logic [TICK_W-1:0] accel_interval;
  } cfg_t;

  typedef struct packed {
    logic accept;   // latch input item, merge event, advance tick count
    logic mul;      // run the shared reciprocal multiplier
    logic exec;     // run one phase of the tick sequence
    logic fin;      // settle direction and load the output register
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

  // Speed command for step n (1..STEP_LEVELS); 0 stops the motor.
  function automatic logic [SPEED_W-1:0] speed_for(input logic mode,
                                                    input logic [STEP_W-1:0] n);
    logic [TABLE_IDX_W-1:0] idx;
    logic [SPEED_W-1:0]     val;
    idx = (n > STEP_W'(TABLE_LEN)) ? TABLE_IDX_W'(TABLE_LEN - 1)
                                   : TABLE_IDX_W'(n - STEP_W'(1));
    if (n == '0) begin
      val = '0;
    end else if (mode) begin
      val = EXP_PERIOD[idx];
    end else begin
      val = LIN_PERIOD[idx];
    end
    return val;
  endfunction

endpackage

@@ rtl/eprc_ctrl.sv @@
// Sequencer for the per-item steps of the encoder position ramp controller.
`timescale 1ns / 1ps

module eprc_ctrl import eprc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        // hold until the output register can take the item
        if (status.out_free) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ rtl/eprc_datapath.sv @@
// Datapath: controller state, shared reciprocal multiplier, speed lookup, output register.
`timescale 1ns / 1ps

module eprc_datapath import eprc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  dp_cmd_t            cmd,
  output dp_status_t         status,
  input  logic               in_encoder_event,
  input  logic               in_turn_clockwise,
  input  logic [POS_W-1:0]   in_position,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_speed_valid,
  output logic [SPEED_W-1:0] out_speed_value,
  output logic               out_spin_ccw,
  output logic [POS_W-1:0]   out_target
);

  // controller state
  logic [POS_W-1:0]   target_r, target_nxt;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [TICK_W-1:0]  tick_r, tick_nxt;
  logic [STEP_W-1:0]  last_step_r, last_step_nxt;
  logic               dir_r, dir_nxt;
  logic               pend_r, pend_nxt;
  logic               pend_cw_r;
  logic               dir_chk_r, dir_chk_nxt;

  // per-item working registers
  logic [POS_W-1:0]   pos_r;
  logic [POS_W-1:0]   mag_r;
  logic [PROD_W-1:0]  prod_r;
  logic               res_valid_r, res_valid_nxt;
  logic [SPEED_W-1:0] res_speed_r, res_speed_nxt;

  // output register
  logic               out_valid_r;
  logic               out_speed_valid_r;
  logic [SPEED_W-1:0] out_speed_value_r;
  logic               out_spin_ccw_r;
  logic [POS_W-1:0]   out_target_r;

  logic [QUOT_W-1:0]  quot;
  logic [POS_W:0]     sum_up;
  logic [STEP_W-1:0]  n_cap;
  logic [STEP_W-1:0]  n_lim;
  logic [STEP_W-1:0]  n_step;
  logic [TICK_W-1:0]  tick_inc;
  logic [POS_W-1:0]   mul_op;
  logic [RECIP_W-1:0] mul_rc;

  assign status.out_free = !out_valid_r || !out_stall;

  // multiplier operand: travel step in idle phase, error magnitude otherwise
  always_comb begin
    if (phase_r == PH_IDLE) begin
      mul_op = cfg.full_travel;
      mul_rc = RECIP_TRAVEL;
    end else begin
      mul_op = mag_r;
      mul_rc = RECIP_ERR;
    end
  end

  assign quot     = prod_r[PROD_W-1:RECIP_SHIFT];
  assign sum_up   = {1'b0, target_r} + (POS_W + 1)'(quot);
  assign n_cap    = (quot > QUOT_W'(STEP_LEVELS)) ? STEP_W'(STEP_LEVELS) : quot[STEP_W-1:0];
  assign n_lim    = last_step_r + STEP_W'(1);
  assign n_step   = (n_cap > n_lim) ? n_lim : n_cap;
  assign tick_inc = tick_r + TICK_W'(1);

  always_comb begin
    target_nxt    = target_r;
    phase_nxt     = phase_r;
    tick_nxt      = tick_r;
    last_step_nxt = last_step_r;
    pend_nxt      = pend_r;
    dir_chk_nxt   = 1'b0;
    res_valid_nxt = 1'b0;
    res_speed_nxt = '0;
    case (phase_r)
      PH_IDLE: begin
        if (pend_r) begin
          pend_nxt    = 1'b0;
          dir_chk_nxt = 1'b1;
          if (pend_cw_r) begin
            target_nxt = (sum_up >= {1'b0, cfg.full_travel}) ? cfg.full_travel
                                                              : sum_up[POS_W-1:0];
          end else begin
            target_nxt = (target_r <= POS_W'(quot)) ? '0 : target_r - POS_W'(quot);
          end
          phase_nxt = (tick_r == '0) ? PH_STEP : PH_WAIT;
        end
      end
      PH_STEP: begin
        last_step_nxt = n_step;
        phase_nxt     = (n_step != '0) ? PH_SPEED : PH_STOP;
      end
      PH_SPEED: begin
        res_valid_nxt = 1'b1;
        res_speed_nxt = speed_for(cfg.speed_mode, last_step_r);
        phase_nxt     = PH_WAIT;
      end
      PH_WAIT: begin
        if (tick_inc >= cfg.accel_interval) begin
          tick_nxt  = '0;
          phase_nxt = PH_STEP;
        end else begin
          tick_nxt = tick_inc;
        end
        if (pend_r) begin
          phase_nxt = PH_IDLE;
        end
      end
      PH_STOP: begin
        res_valid_nxt = 1'b1;
        phase_nxt     = PH_IDLE;
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  // direction follows the sign of the error after a setpoint move
  always_comb begin
    dir_nxt = dir_r;
    if (dir_chk_r) begin
      if (target_r > pos_r) begin
        dir_nxt = 1'b0;
      end else if (target_r < pos_r) begin
        dir_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r    <= '0;
      phase_r     <= PH_IDLE;
      tick_r      <= '0;
      last_step_r <= '0;
      dir_r       <= 1'b0;
      pend_r      <= 1'b0;
      pend_cw_r   <= 1'b0;
      dir_chk_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.accept) begin
        tick_r <= tick_inc;
        if (in_encoder_event) begin
          pend_r    <= 1'b1;
          pend_cw_r <= in_turn_clockwise;
        end
      end
      if (cmd.exec) begin
        target_r    <= target_nxt;
        phase_r     <= phase_nxt;
        tick_r      <= tick_nxt;
        last_step_r <= last_step_nxt;
        pend_r      <= pend_nxt;
        dir_chk_r   <= dir_chk_nxt;
      end
      if (cmd.fin) begin
        dir_r       <= dir_nxt;
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pos_r <= in_position;
      mag_r <= (target_r >= in_position) ? target_r - in_position : in_position - target_r;
    end
    if (cmd.mul) begin
      prod_r <= {{RECIP_W{1'b0}}, mul_op} * {{POS_W{1'b0}}, mul_rc};
    end
    if (cmd.exec) begin
      res_valid_r <= res_valid_nxt;
      res_speed_r <= res_speed_nxt;
    end
    if (cmd.fin) begin
      out_speed_valid_r <= res_valid_r;
      out_speed_value_r <= res_speed_r;
      out_spin_ccw_r    <= dir_nxt;
      out_target_r      <= target_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_speed_valid = out_speed_valid_r;
  assign out_speed_value = out_speed_value_r;
  assign out_spin_ccw    = out_spin_ccw_r;
  assign out_target      = out_target_r;

endmodule

@@ rtl/encoder_position_ramp_controller.sv @@
// Top level of the encoder position ramp controller: config registers, sequencer, datapath.
`timescale 1ns / 1ps
// An accepted item passes the multiply and phase states, then is loaded into the
// output register once it is free. No new item is taken until that hand-off; the
//   shared reciprocal multiplier and the one-phase-per-tick sequence set this.
// A result waiting in the output register does not block accepting the next item.
// Reset (synchronous, rst_n low): registers to travel 100000, linear mode,
//   interval 150; setpoint, phase, tick count, step, direction and pending event cleared.

module encoder_position_ramp_controller import eprc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration write port
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [POS_W-1:0]     cfg_wdata,
  // tick items in
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_encoder_event,
  input  logic                 in_turn_clockwise,
  input  logic [POS_W-1:0]     in_position,
  // result items out
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_speed_valid,
  output logic [SPEED_W-1:0]   out_speed_value,
  output logic                 out_spin_ccw,
  output logic [POS_W-1:0]     out_target
);

  cfg_t       cfg_r;
  dp_cmd_t    cmd;
  dp_status_t status;

  // Register file: the user must write only while idle; the block does not enforce it and applies writes directly.
  // Writes to an unknown index drop silently.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.full_travel    <= RST_FULL_TRAVEL;
      cfg_r.speed_mode     <= 1'b0;
      cfg_r.accel_interval <= RST_ACCEL_INTERVAL;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_FULL_TRAVEL:    cfg_r.full_travel    <= cfg_wdata;
        CFG_SPEED_MODE:     cfg_r.speed_mode     <= cfg_wdata[0];
        CFG_ACCEL_INTERVAL: cfg_r.accel_interval <= cfg_wdata[TICK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer: accept, multiply, run one phase, then hand off to the output register.
  eprc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath holds all tick state plus the output register.
  eprc_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .cmd               (cmd),
    .status            (status),
    .in_encoder_event  (in_encoder_event),
    .in_turn_clockwise (in_turn_clockwise),
    .in_position       (in_position),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_speed_valid   (out_speed_valid),
    .out_speed_value   (out_speed_value),
    .out_spin_ccw      (out_spin_ccw),
    .out_target        (out_target)
  );

  // After taking an item the block stays busy while it works on it.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after accepting an item");

  // A nonzero speed only travels with a speed command.
  a_speed_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_speed_value != '0) |-> out_speed_valid)
    else $error("nonzero speed without a speed command");

  // Speed commands stay within the longest step period.
  a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_speed_valid) |-> (out_speed_value <= MAX_PERIOD))
    else $error("speed command beyond the longest period");

endmodule
